// ===== design/sab_pkg.sv =====
// Shared types and constants for the configuration port bridge.
`default_nettype none
package sab_pkg;

   // Host access byte codes
   localparam logic [7:0] KEY_BYTE    = 8'hA5;
   localparam logic [7:0] LOCK_BYTE   = 8'hAA;
   localparam logic [7:0] TRIGGER_WR  = 8'hCF;
   localparam logic [7:0] LDN_BRIDGE  = 8'h0D;
   localparam logic [7:0] RD_UNMAPPED = 8'hFF;

   // Register indexes
   localparam logic [7:0] REG_LDN     = 8'h07;
   localparam logic [7:0] REG_ENABLE  = 8'h30;
   localparam logic [7:0] REG_ADDR0   = 8'hF0;
   localparam logic [7:0] REG_DATA0   = 8'hF4;
   localparam logic [7:0] REG_SIZE    = 8'hF8;
   localparam logic [7:0] REG_TRIGGER = 8'hFE;

   localparam logic PORT_INDEX = 1'b0;
   localparam logic PORT_DATA  = 1'b1;

   localparam logic [1:0] SIZE_WORD = 2'd2;
   localparam logic [1:0] SIZE_SAT  = 2'd3;

   typedef enum logic [1:0] {
      REQ_IO_WRITE = 2'd0,
      REQ_IO_READ  = 2'd1,
      REQ_BUS_CPL  = 2'd2
   } req_kind_type;

   typedef enum logic [1:0] {
      CMD_NONE  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_WRITE = 2'd2
   } bus_cmd_type;

   typedef struct packed {
      logic [1:0]  req_kind;
      logic        port_sel;
      logic [7:0]  wdata;
      logic [31:0] bus_rdata;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  io_rdata;
      logic [1:0]  bus_cmd;
      logic [31:0] bus_addr;
      logic [31:0] bus_wdata;
      logic [1:0]  bus_size;
   } rsp_item_type;

endpackage
`default_nettype wire

// ===== design/sab_core.sv =====
// Port state registers and single-pass decode of one host transaction.
`default_nettype none
module sab_core
   import sab_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire req_item_type item,
   input  wire logic         fire,
   output rsp_item_type      result,
   output logic              has_result
);

   logic        key_seen_ff, key_seen_in;
   logic        unlocked_ff, unlocked_in;
   logic [7:0]  index_ff, index_in;
   logic [7:0]  ldn_ff, ldn_in;
   logic        enable_ff, enable_in;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] data_ff, data_in;
   logic [1:0]  size_ff, size_in;

   always_comb begin
      logic       bridge;
      logic [1:0] lane;
      logic [7:0] rd;
      logic       is_addr;
      logic       is_data;

      key_seen_in = key_seen_ff;
      unlocked_in = unlocked_ff;
      index_in    = index_ff;
      ldn_in      = ldn_ff;
      enable_in   = enable_ff;
      addr_in     = addr_ff;
      data_in     = data_ff;
      size_in     = size_ff;
      result      = '0;
      has_result  = 1'b0;

      bridge  = (ldn_ff == LDN_BRIDGE);
      lane    = ~index_ff[1:0];
      is_addr = (index_ff[7:2] == REG_ADDR0[7:2]);
      is_data = (index_ff[7:2] == REG_DATA0[7:2]);
      rd      = RD_UNMAPPED;

      case (req_kind_type'(item.req_kind))
         REQ_BUS_CPL: begin
            data_in = item.bus_rdata;
         end
         REQ_IO_WRITE: begin
            if (item.port_sel == PORT_INDEX) begin
               if (!unlocked_ff) begin
                  if (item.wdata == KEY_BYTE) begin
                     unlocked_in = key_seen_ff;
                     key_seen_in = !key_seen_ff;
                  end else begin
                     key_seen_in = 1'b0;
                  end
               end else if (item.wdata == LOCK_BYTE) begin
                  unlocked_in = 1'b0;
                  key_seen_in = 1'b0;
               end else begin
                  index_in = item.wdata;
               end
            end else if (unlocked_ff) begin
               if (index_ff == REG_LDN) begin
                  ldn_in = item.wdata;
               end else if (bridge) begin
                  if (index_ff == REG_ENABLE) begin
                     enable_in = item.wdata[0];
                  end else if (is_addr) begin
                     addr_in[{lane, 3'b000} +: 8] = item.wdata;
                  end else if (is_data) begin
                     data_in[{lane, 3'b000} +: 8] = item.wdata;
                  end else if (index_ff == REG_SIZE) begin
                     size_in = (item.wdata[1:0] == SIZE_SAT) ? SIZE_WORD : item.wdata[1:0];
                  end else if (index_ff == REG_TRIGGER) begin
                     if (enable_ff && item.wdata == TRIGGER_WR) begin
                        has_result       = 1'b1;
                        result.bus_cmd   = CMD_WRITE;
                        result.bus_addr  = addr_ff;
                        result.bus_wdata = data_ff;
                        result.bus_size  = size_ff;
                     end
                  end
               end
            end
         end
         REQ_IO_READ: begin
            has_result = 1'b1;
            if (unlocked_ff) begin
               if (item.port_sel == PORT_INDEX) begin
                  rd = index_ff;
               end else if (index_ff == REG_LDN) begin
                  rd = ldn_ff;
               end else if (bridge) begin
                  if (index_ff == REG_ENABLE) begin
                     rd = {7'b0, enable_ff};
                  end else if (is_addr) begin
                     rd = addr_ff[{lane, 3'b000} +: 8];
                  end else if (is_data) begin
                     rd = data_ff[{lane, 3'b000} +: 8];
                  end else if (index_ff == REG_SIZE) begin
                     rd = {6'b0, size_ff};
                  end else if (index_ff == REG_TRIGGER) begin
                     rd = 8'h00;
                     if (enable_ff) begin
                        result.bus_cmd  = CMD_READ;
                        result.bus_addr = addr_ff;
                        result.bus_size = size_ff;
                     end
                  end
               end
            end
            result.io_rdata = rd;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_seen_ff <= 1'b0;
         unlocked_ff <= 1'b0;
         index_ff    <= '0;
         ldn_ff      <= '0;
         enable_ff   <= 1'b0;
         addr_ff     <= '0;
         data_ff     <= '0;
         size_ff     <= SIZE_WORD;
      end else if (fire) begin
         key_seen_ff <= key_seen_in;
         unlocked_ff <= unlocked_in;
         index_ff    <= index_in;
         ldn_ff      <= ldn_in;
         enable_ff   <= enable_in;
         addr_ff     <= addr_in;
         data_ff     <= data_in;
         size_ff     <= size_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/superio_ahb_bridge.sv =====
// Top level of the index/data configuration port bridge.
// Each host transaction is captured in an input register, decoded against the
// port state in one pass, and any result lands in an output register, so the
// block takes one transaction every cycle. A result is valid once its transaction
// leaves the input register. req_ready drops only when the input register
// holds a transaction that produces a result while the output register is full
// and not being drained in that cycle; transactions without a result never wait.
`default_nettype none
module superio_ahb_bridge
   import sab_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic        req_port_sel,
   input  wire logic [7:0]  req_wdata,
   input  wire logic [31:0] req_bus_rdata,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_io_rdata,
   output logic [1:0]       rsp_bus_cmd,
   output logic [31:0]      rsp_bus_addr,
   output logic [31:0]      rsp_bus_wdata,
   output logic [1:0]       rsp_bus_size
);

   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff;

   rsp_item_type result;
   logic         has_result;
   logic         out_free;
   logic         advance;

   sab_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item       (in_item_ff),
      .fire       (advance),
      .result     (result),
      .has_result (has_result)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!has_result || out_free);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (advance && has_result) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on capture, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= '{req_kind: req_type, port_sel: req_port_sel,
                         wdata: req_wdata, bus_rdata: req_bus_rdata};
      end
      if (advance && has_result) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_io_rdata  = rsp_item_ff.io_rdata;
   assign rsp_bus_cmd   = rsp_item_ff.bus_cmd;
   assign rsp_bus_addr  = rsp_item_ff.bus_addr;
   assign rsp_bus_wdata = rsp_item_ff.bus_wdata;
   assign rsp_bus_size  = rsp_item_ff.bus_size;

endmodule
`default_nettype wire

// ===== design/sab_checker.sv =====
// Port-level checks for the configuration port bridge, bound to the top level.
`default_nettype none
module sab_checker
   import sab_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic [1:0]  req_type,
   input wire logic        req_port_sel,
   input wire logic [7:0]  req_wdata,
   input wire logic [31:0] req_bus_rdata,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [7:0]  rsp_io_rdata,
   input wire logic [1:0]  rsp_bus_cmd,
   input wire logic [31:0] rsp_bus_addr,
   input wire logic [31:0] rsp_bus_wdata,
   input wire logic [1:0]  rsp_bus_size
);

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_io_rdata)
      && $stable(rsp_bus_cmd) && $stable(rsp_bus_addr)
      && $stable(rsp_bus_wdata) && $stable(rsp_bus_size))
      else $error("response changed while stalled");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid right after reset");

   a_idle_bus_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bus_cmd == CMD_NONE |-> rsp_bus_addr == 32'h0
      && rsp_bus_wdata == 32'h0 && rsp_bus_size == 2'd0)
      else $error("bus fields set without a bus command");

   a_cmd_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bus_cmd != CMD_NONE |-> rsp_io_rdata == 8'h00
      && rsp_bus_size != SIZE_SAT
      && (rsp_bus_cmd == CMD_READ || rsp_bus_cmd == CMD_WRITE)
      && (rsp_bus_cmd == CMD_WRITE || rsp_bus_wdata == 32'h0))
      else $error("malformed bus command response");

endmodule

bind superio_ahb_bridge sab_checker u_sab_checker (.*);
`default_nettype wire

// ===== bench/superio_ahb_bridge_test.sv =====
// Self-checking testbench for the configuration port bridge: directed and random traffic.
`timescale 1ns / 1ps
module superio_ahb_bridge_test;
   import sab_pkg::*;

   localparam logic [1:0] REQ_RESERVED   = 2'd3;
   localparam int         RESULT_LATENCY = 2;
   localparam int         DRAIN_LIMIT    = 20000;
   localparam int         HOLD_CYCLES    = 300;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type      = REQ_IO_WRITE;
   logic        req_port_sel  = PORT_INDEX;
   logic [7:0]  req_wdata     = '0;
   logic [31:0] req_bus_rdata = '0;
   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic [7:0]  rsp_io_rdata;
   logic [1:0]  rsp_bus_cmd;
   logic [31:0] rsp_bus_addr;
   logic [31:0] rsp_bus_wdata;
   logic [1:0]  rsp_bus_size;

   // port state as the bridge should hold it
   logic        pr_key_seen = 1'b0;
   logic        pr_unlocked = 1'b0;
   logic [7:0]  pr_index    = '0;
   logic [7:0]  pr_ldn      = '0;
   logic        pr_enable   = 1'b0;
   logic [31:0] pr_addr     = '0;
   logic [31:0] pr_data     = '0;
   logic [1:0]  pr_size     = SIZE_WORD;

   rsp_item_type expected_rsp[$];

   int unsigned tx_idle_pct     = 0;
   int unsigned rx_stall_pct    = 0;
   int unsigned rx_hold_cycles  = 0;
   int unsigned items_sent      = 0;
   int unsigned results_checked = 0;
   int unsigned bus_reads_seen  = 0;
   int unsigned bus_writes_seen = 0;
   int unsigned mismatches      = 0;

   superio_ahb_bridge u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_type      (req_type),
      .req_port_sel  (req_port_sel),
      .req_wdata     (req_wdata),
      .req_bus_rdata (req_bus_rdata),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_io_rdata  (rsp_io_rdata),
      .rsp_bus_cmd   (rsp_bus_cmd),
      .rsp_bus_addr  (rsp_bus_addr),
      .rsp_bus_wdata (rsp_bus_wdata),
      .rsp_bus_size  (rsp_bus_size)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("timeout: run did not complete, %0d results still outstanding",
               expected_rsp.size());
      $display("FAIL");
      $finish;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t ns: %s got %h expected %h", $time, what, got, want);
      mismatches++;
   endtask

   // Update the port state for one accepted transaction and queue its result.
   task automatic predict_access(input logic [1:0] kind, input logic port,
                                 input logic [7:0] wd, input logic [31:0] brd);
      rsp_item_type rsp;
      logic         produce;
      logic         is_bridge;
      logic [7:0]   idx;
      rsp       = '0;
      produce   = 1'b0;
      is_bridge = (pr_ldn == LDN_BRIDGE);
      idx       = pr_index;
      case (kind)
         REQ_BUS_CPL: pr_data = brd;
         REQ_IO_WRITE: begin
            if (port == PORT_INDEX) begin
               if (!pr_unlocked) begin
                  if (wd == KEY_BYTE) begin
                     if (pr_key_seen) begin
                        pr_unlocked = 1'b1;
                        pr_key_seen = 1'b0;
                     end else begin
                        pr_key_seen = 1'b1;
                     end
                  end else begin
                     pr_key_seen = 1'b0;
                  end
               end else if (wd == LOCK_BYTE) begin
                  pr_unlocked = 1'b0;
                  pr_key_seen = 1'b0;
               end else begin
                  pr_index = wd;
               end
            end else if (pr_unlocked) begin
               if (idx == REG_LDN) begin
                  pr_ldn = wd;
               end else if (is_bridge) begin
                  if (idx == REG_ENABLE) begin
                     pr_enable = wd[0];
                  end else if (idx >= REG_ADDR0 && idx < REG_DATA0) begin
                     pr_addr[8 * (3 - idx[1:0]) +: 8] = wd;
                  end else if (idx >= REG_DATA0 && idx < REG_SIZE) begin
                     pr_data[8 * (3 - idx[1:0]) +: 8] = wd;
                  end else if (idx == REG_SIZE) begin
                     pr_size = (wd[1:0] == SIZE_SAT) ? SIZE_WORD : wd[1:0];
                  end else if (idx == REG_TRIGGER && pr_enable && wd == TRIGGER_WR) begin
                     produce       = 1'b1;
                     rsp.bus_cmd   = CMD_WRITE;
                     rsp.bus_addr  = pr_addr;
                     rsp.bus_wdata = pr_data;
                     rsp.bus_size  = pr_size;
                  end
               end
            end
         end
         REQ_IO_READ: begin
            produce      = 1'b1;
            rsp.io_rdata = RD_UNMAPPED;
            if (pr_unlocked) begin
               if (port == PORT_INDEX) begin
                  rsp.io_rdata = pr_index;
               end else if (idx == REG_LDN) begin
                  rsp.io_rdata = pr_ldn;
               end else if (is_bridge) begin
                  if (idx == REG_ENABLE) begin
                     rsp.io_rdata = {7'd0, pr_enable};
                  end else if (idx >= REG_ADDR0 && idx < REG_DATA0) begin
                     rsp.io_rdata = pr_addr[8 * (3 - idx[1:0]) +: 8];
                  end else if (idx >= REG_DATA0 && idx < REG_SIZE) begin
                     rsp.io_rdata = pr_data[8 * (3 - idx[1:0]) +: 8];
                  end else if (idx == REG_SIZE) begin
                     rsp.io_rdata = {6'd0, pr_size};
                  end else if (idx == REG_TRIGGER) begin
                     rsp.io_rdata = '0;
                     if (pr_enable) begin
                        rsp.bus_cmd  = CMD_READ;
                        rsp.bus_addr = pr_addr;
                        rsp.bus_size = pr_size;
                     end
                  end
               end
            end
         end
         default: ;
      endcase
      if (produce)
         expected_rsp.push_back(rsp);
   endtask

   // Offer one transaction, idling first at the current rate, and wait for acceptance.
   task automatic send_access(input logic [1:0] kind, input logic port,
                              input logic [7:0] wd, input logic [31:0] brd);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid     <= 1'b0;
         req_type      <= 2'($urandom_range(3));
         req_port_sel  <= 1'($urandom_range(1));
         req_wdata     <= 8'($urandom);
         req_bus_rdata <= $urandom;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_port_sel  <= port;
      req_wdata     <= wd;
      req_bus_rdata <= brd;
      do @(posedge clock); while (!req_ready);
      predict_access(kind, port, wd, brd);
      if (kind != REQ_RESERVED)
         items_sent++;
   endtask

   // Drop valid and wait until every queued result has been checked.
   task automatic wait_results_drained();
      int unsigned waited;
      waited = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_rsp.size() != 0) begin
         report_mismatch("results never delivered, count", expected_rsp.size(), 0);
         expected_rsp.delete();
      end
      repeat (RESULT_LATENCY + 4) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (rx_hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         rx_hold_cycles--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin : check_results
      rsp_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            report_mismatch("unexpected result, io_rdata", 32'(rsp_io_rdata), 0);
         end else begin
            want = expected_rsp.pop_front();
            results_checked++;
            if (rsp_bus_cmd == CMD_READ)
               bus_reads_seen++;
            if (rsp_bus_cmd == CMD_WRITE)
               bus_writes_seen++;
            if (rsp_io_rdata !== want.io_rdata)
               report_mismatch("io_rdata", 32'(rsp_io_rdata), 32'(want.io_rdata));
            if (rsp_bus_cmd !== want.bus_cmd)
               report_mismatch("bus_cmd", 32'(rsp_bus_cmd), 32'(want.bus_cmd));
            if (rsp_bus_addr !== want.bus_addr)
               report_mismatch("bus_addr", rsp_bus_addr, want.bus_addr);
            if (rsp_bus_wdata !== want.bus_wdata)
               report_mismatch("bus_wdata", rsp_bus_wdata, want.bus_wdata);
            if (rsp_bus_size !== want.bus_size)
               report_mismatch("bus_size", 32'(rsp_bus_size), 32'(want.bus_size));
         end
      end
   end

   function automatic logic [7:0] pick_register();
      case ($urandom_range(9))
         0:       return REG_LDN;
         1:       return REG_ENABLE;
         2, 3:    return 8'(REG_ADDR0 + $urandom_range(3));
         4, 5:    return 8'(REG_DATA0 + $urandom_range(3));
         6:       return REG_SIZE;
         7:       return REG_TRIGGER;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Pick one short host sequence; steer back into the bridge when the state drifts.
   task automatic send_random_sequence();
      int unsigned pick;
      logic [7:0]  reg_idx;
      pick    = $urandom_range(99);
      reg_idx = pick_register();
      if (!pr_unlocked && pick < 90) begin
         send_access(REQ_IO_WRITE, PORT_INDEX, KEY_BYTE, $urandom);
         if ($urandom_range(9) == 0)
            send_access(REQ_IO_WRITE, PORT_INDEX, 8'($urandom), $urandom);
         send_access(REQ_IO_WRITE, PORT_INDEX, KEY_BYTE, $urandom);
      end else if (pr_ldn != LDN_BRIDGE && pick < 70) begin
         send_access(REQ_IO_WRITE, PORT_INDEX, REG_LDN, $urandom);
         send_access(REQ_IO_WRITE, PORT_DATA,
                     ($urandom_range(9) != 0) ? LDN_BRIDGE : 8'($urandom), $urandom);
      end else if (!pr_enable && pick < 70) begin
         send_access(REQ_IO_WRITE, PORT_INDEX, REG_ENABLE, $urandom);
         send_access(REQ_IO_WRITE, PORT_DATA,
                     {7'($urandom), ($urandom_range(99) < 85)}, $urandom);
      end else if (pick < 8) begin
         send_access(2'($urandom_range(3)), 1'($urandom_range(1)), 8'($urandom), $urandom);
      end else if (pick < 14) begin
         send_access(REQ_BUS_CPL, 1'($urandom_range(1)), 8'($urandom), $urandom);
      end else if (pick < 18) begin
         send_access(REQ_IO_WRITE, PORT_INDEX, LOCK_BYTE, $urandom);
      end else if (pick < 34) begin
         send_access(REQ_IO_WRITE, PORT_INDEX, REG_TRIGGER, $urandom);
         send_access(REQ_IO_WRITE, PORT_DATA,
                     ($urandom_range(9) < 8) ? TRIGGER_WR : 8'($urandom), $urandom);
      end else if (pick < 46) begin
         send_access(REQ_IO_WRITE, PORT_INDEX, REG_TRIGGER, $urandom);
         send_access(REQ_IO_READ, PORT_DATA, 8'($urandom), $urandom);
      end else if (pick < 74) begin
         // reuse the current index now and then
         if ($urandom_range(9) < 7)
            send_access(REQ_IO_WRITE, PORT_INDEX, reg_idx, $urandom);
         send_access(REQ_IO_WRITE, PORT_DATA, 8'($urandom), $urandom);
      end else begin
         if ($urandom_range(9) < 7)
            send_access(REQ_IO_WRITE, PORT_INDEX, reg_idx, $urandom);
         send_access(REQ_IO_READ, ($urandom_range(4) == 0) ? PORT_INDEX : PORT_DATA,
                     8'($urandom), $urandom);
      end
   endtask

   task automatic test_locked_port();
      send_access(REQ_IO_READ,  PORT_INDEX, 8'h00, 32'h0);
      send_access(REQ_IO_READ,  PORT_DATA,  8'hFF, 32'hFFFF_FFFF);
      send_access(REQ_IO_WRITE, PORT_DATA,  8'h55, 32'h0);
      // a broken key pair must not unlock
      send_access(REQ_IO_WRITE, PORT_INDEX, KEY_BYTE, 32'h0);
      send_access(REQ_IO_WRITE, PORT_INDEX, 8'h00, 32'h0);
      send_access(REQ_IO_WRITE, PORT_INDEX, KEY_BYTE, 32'h0);
      send_access(REQ_IO_READ,  PORT_DATA,  8'h00, 32'h0);
      send_access(REQ_IO_WRITE, PORT_INDEX, KEY_BYTE, 32'h0);
      send_access(REQ_IO_READ,  PORT_INDEX, 8'h00, 32'h0);
   endtask

   task automatic test_bridge_registers();
      // other logical device: bridge registers are dead
      send_access(REQ_IO_WRITE, PORT_INDEX, REG_ADDR0, 32'h0);
      send_access(REQ_IO_WRITE, PORT_DATA,  8'hFF, 32'h0);
      send_access(REQ_IO_WRITE, PORT_INDEX, REG_LDN, 32'h0);
      send_access(REQ_IO_WRITE, PORT_DATA,  LDN_BRIDGE, 32'h0);
      send_access(REQ_IO_WRITE, PORT_INDEX, REG_ENABLE, 32'h0);
      send_access(REQ_IO_WRITE, PORT_DATA,  8'hFF, 32'h0);
      send_access(REQ_IO_WRITE, PORT_INDEX, REG_ADDR0, 32'h0);
      send_access(REQ_IO_WRITE, PORT_DATA,  8'h80, 32'h0);
      send_access(REQ_IO_WRITE, PORT_INDEX, REG_SIZE, 32'h0);
      send_access(REQ_IO_WRITE, PORT_DATA,  8'hFF, 32'h0);
      send_access(REQ_BUS_CPL,  PORT_DATA,  8'hFF, 32'hFFFF_FFFF);
      send_access(REQ_IO_WRITE, PORT_INDEX, REG_TRIGGER, 32'h0);
      send_access(REQ_IO_WRITE, PORT_DATA,  8'h00, 32'h0);
      send_access(REQ_IO_WRITE, PORT_DATA,  TRIGGER_WR, 32'h0);
      send_access(REQ_IO_READ,  PORT_DATA,  8'h00, 32'h0);
      send_access(REQ_RESERVED, PORT_DATA,  8'hFF, 32'hFFFF_FFFF);
      send_access(REQ_IO_WRITE, PORT_INDEX, 8'h55, 32'h0);
      send_access(REQ_IO_READ,  PORT_DATA,  8'h00, 32'h0);
      send_access(REQ_IO_WRITE, PORT_INDEX, LOCK_BYTE, 32'h0);
      wait_results_drained();
   endtask

   task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
                                      input int unsigned stall_pct);
      int unsigned stop_at;
      tx_idle_pct  = idle_pct;
      rx_stall_pct = stall_pct;
      stop_at      = items_sent + count;
      while (items_sent < stop_at)
         send_random_sequence();
      wait_results_drained();
   endtask

   // Hold off the receiver while reads keep coming, so the input backs up.
   task automatic test_output_backpressure();
      tx_idle_pct    = 0;
      rx_stall_pct   = 0;
      rx_hold_cycles = HOLD_CYCLES;
      repeat (40)
         send_access(REQ_IO_READ, 1'($urandom_range(1)), 8'($urandom), $urandom);
      wait_results_drained();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_locked_port();
      test_bridge_registers();
      test_random_traffic(150, 0, 0);
      test_random_traffic(150, 63, 0);
      test_random_traffic(150, 0, 63);
      test_random_traffic(150, 22, 22);
      test_output_backpressure();

      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      wait_results_drained();
      $display("%0d transactions sent, %0d results checked (%0d bus reads, %0d bus writes)",
               items_sent, results_checked, bus_reads_seen, bus_writes_seen);
      $display("covered: key/lock sequence, bridge registers, triggers, idle and stall mixes,");
      $display("         and a long receiver hold with the input backed up");
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/sab_pkg.sv
design/sab_core.sv
design/superio_ahb_bridge.sv
design/sab_checker.sv
bench/superio_ahb_bridge_test.sv
